// ----- hw/rtl/swmc_pkg.sv -----
package swmc_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int TERM_W     = SAMPLE_W + 1;  // room to negate the most negative sample
  localparam int COST_W     = 38;
  localparam int WLEN_W     = 7;
  localparam int MAX_WINDOW = 64;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd1;

  // Per-cell status handed up the chain
  typedef struct packed {
    logic le;   // occupied and value <= incoming sample
    logic rbe;  // the dropped entry sits at or below this cell
  } swmc_link_t;

endpackage

// ----- hw/rtl/sliding_window_median_cost.sv -----
// Sliding-window median cost.
// Input channel in_valid/in_ready carries in_sample (signed) and in_restart.
// Every accepted word is inserted into a sorted chain of MaxWindow cells; the
// oldest word is dropped once the window holds K = cfg_wdata words (0 acts as
// 1, values above MaxWindow act as MaxWindow). in_restart empties the window
// before its sample is taken. Once K words are held, each word produces one
// out_cost on out_valid/out_ready: the sum of absolute deviations from the
// window's lower median.
// Words that produce no result are taken one per cycle while no sum is
// pending. A word that produces a result keeps in_ready low until its sum
// has gone through the registered adder tree and been loaded into the
// output register. in_ready returns the cycle after the load, so the next
// word is not taken before the last sum is loaded.
// The result sits in an output register; if the receiver stalls, the next
// word is still taken, its sum waits at the tree root and in_ready stays low
// until the output register frees up.
// cfg_we writes the window length and empties the window; write only when idle.
// Reset (synchronous, rst_n low) sets K to 1 and empties the window; cell
// contents are not cleared, only the fill count.
module sliding_window_median_cost #(
  parameter int MaxWindow = swmc_pkg::MAX_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swmc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [swmc_pkg::COST_W-1:0]          out_cost,
  input  logic                                 cfg_we,
  input  logic [swmc_pkg::WLEN_W-1:0]          cfg_wdata
);
  import swmc_pkg::*;

  localparam int CntW    = $clog2(MaxWindow + 1);
  localparam int AgeW    = $clog2(MaxWindow);
  localparam int TreeLvl = $clog2(MaxWindow);
  localparam int TreeLat = TreeLvl + 1;
  localparam int BcW     = $clog2(TreeLat + 1);
  localparam int AccW    = (TERM_W + TreeLvl > COST_W) ? TERM_W + TreeLvl : COST_W;

  logic [WLEN_W-1:0]          wlen_r;
  logic [CntW-1:0]            fill_r;
  logic                       busy_r;
  logic [BcW-1:0]             bcnt_r;
  logic                       out_valid_r;
  logic [COST_W-1:0]          out_cost_r;

  logic [CntW-1:0]            k_eff;
  logic [CntW-1:0]            low_cnt;
  logic [AgeW-1:0]            drop_age;
  logic [CntW-1:0]            fill_eff;
  logic [CntW-1:0]            fill_nxt;
  logic                       full;
  logic                       make_res;
  logic                       accept;
  logic                       load;
  logic signed [AccW-1:0]     root;

  swmc_link_t                 cell_link [MaxWindow];
  logic signed [SAMPLE_W-1:0] cell_val  [MaxWindow];
  logic [AgeW-1:0]            cell_age  [MaxWindow];
  logic signed [TERM_W-1:0]   cell_term [MaxWindow];

  always_comb begin
    if (wlen_r == '0) begin
      k_eff = CntW'(1);
    end else if (int'(wlen_r) > MaxWindow) begin
      k_eff = CntW'(MaxWindow);
    end else begin
      k_eff = CntW'(wlen_r);
    end
  end

  assign low_cnt  = CntW'((32'(k_eff) + 32'd1) >> 1);
  assign drop_age = AgeW'(k_eff - CntW'(1));
  assign fill_eff = in_restart ? '0 : fill_r;
  assign full     = fill_eff == k_eff;
  assign fill_nxt = full ? fill_eff : fill_eff + CntW'(1);
  assign make_res = fill_nxt == k_eff;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign load     = busy_r && (bcnt_r == BcW'(TreeLat)) && (!out_valid_r || out_ready);

  for (genvar g = 0; g < MaxWindow; g++) begin : g_cell
    swmc_link_t                 lo_link;
    logic signed [SAMPLE_W-1:0] lo_val;
    logic [AgeW-1:0]            lo_age;
    logic                       hi_le;
    logic signed [SAMPLE_W-1:0] hi_val;
    logic [AgeW-1:0]            hi_age;

    if (g == 0) begin : g_bottom
      assign lo_link = '{le: 1'b1, rbe: 1'b0};
      assign lo_val  = '0;
      assign lo_age  = '0;
    end else begin : g_lo
      assign lo_link = cell_link[g-1];
      assign lo_val  = cell_val[g-1];
      assign lo_age  = cell_age[g-1];
    end

    if (g == MaxWindow - 1) begin : g_top
      assign hi_le  = 1'b0;
      assign hi_val = '0;
      assign hi_age = '0;
    end else begin : g_hi
      assign hi_le  = cell_link[g+1].le;
      assign hi_val = cell_val[g+1];
      assign hi_age = cell_age[g+1];
    end

    swmc_cell #(
      .Idx  (g),
      .AgeW (AgeW),
      .CntW (CntW)
    ) u_cell (
      .clk      (clk),
      .en       (accept),
      .sample   (in_sample),
      .fill     (fill_eff),
      .full     (full),
      .drop_age (drop_age),
      .win_len  (k_eff),
      .low_cnt  (low_cnt),
      .lo_link  (lo_link),
      .lo_val   (lo_val),
      .lo_age   (lo_age),
      .hi_le    (hi_le),
      .hi_val   (hi_val),
      .hi_age   (hi_age),
      .link     (cell_link[g]),
      .val_r    (cell_val[g]),
      .age_r    (cell_age[g]),
      .term     (cell_term[g])
    );
  end

  swmc_sum_tree #(
    .NumIn (MaxWindow),
    .AccW  (AccW)
  ) u_sum_tree (
    .clk  (clk),
    .term (cell_term),
    .sum  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= WLEN_RESET;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wlen_r <= cfg_wdata;
        fill_r <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
      end

      // wait for the tree to settle, then park the sum in the output register
      if (accept && make_res) begin
        busy_r <= 1'b1;
        bcnt_r <= '0;
      end else if (busy_r) begin
        if (bcnt_r != BcW'(TreeLat)) begin
          bcnt_r <= bcnt_r + BcW'(1);
        end else if (!out_valid_r || out_ready) begin
          busy_r <= 1'b0;
        end
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cost_r <= root[COST_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= k_eff)
    else $error("fill count above window length");

  a_busy_full : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (fill_r == k_eff))
    else $error("sum pending while window not full");

  a_res_from_tree : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result word without pending sum");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BcW'(TreeLat))
    else $error("tree wait counter overran");

  for (genvar g = 0; g < MaxWindow - 1; g++) begin : g_chk_sorted
    a_sorted : assert property (@(posedge clk) disable iff (!rst_n)
      (CntW'(g + 1) < fill_r) |-> (cell_val[g] <= cell_val[g+1]))
      else $error("cell chain out of order");
  end

endmodule

// ----- hw/rtl/swmc_cell.sv -----
module swmc_cell #(
  parameter int Idx  = 0,
  parameter int AgeW = 6,
  parameter int CntW = 7
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [swmc_pkg::SAMPLE_W-1:0]  sample,
  input  logic [CntW-1:0]                       fill,
  input  logic                                  full,
  input  logic [AgeW-1:0]                       drop_age,
  input  logic [CntW-1:0]                       win_len,
  input  logic [CntW-1:0]                       low_cnt,
  input  swmc_pkg::swmc_link_t                  lo_link,
  input  logic signed [swmc_pkg::SAMPLE_W-1:0]  lo_val,
  input  logic [AgeW-1:0]                       lo_age,
  input  logic                                  hi_le,
  input  logic signed [swmc_pkg::SAMPLE_W-1:0]  hi_val,
  input  logic [AgeW-1:0]                       hi_age,
  output swmc_pkg::swmc_link_t                  link,
  output logic signed [swmc_pkg::SAMPLE_W-1:0]  val_r,
  output logic [AgeW-1:0]                       age_r,
  output logic signed [swmc_pkg::TERM_W-1:0]    term
);
  import swmc_pkg::*;

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  logic                       occ;
  logic                       le;
  logic                       drop;
  logic                       rbe;
  logic                       lep_cur;
  logic                       lep_prev;
  logic signed [SAMPLE_W-1:0] sp_cur_val;
  logic signed [SAMPLE_W-1:0] sp_prev_val;
  logic [AgeW-1:0]            sp_cur_age;
  logic [AgeW-1:0]            sp_prev_age;
  logic signed [SAMPLE_W-1:0] val_nxt;
  logic [AgeW-1:0]            age_nxt;
  logic signed [TERM_W-1:0]   val_ext;

  assign occ  = IdxC < fill;
  assign le   = occ && (val_r <= sample);
  assign drop = full && occ && (age_r == drop_age);
  assign rbe  = lo_link.rbe | drop;
  assign link = '{le: le, rbe: rbe};

  // Entry at this slot and the one below once the oldest word is dropped
  assign sp_cur_val  = rbe ? hi_val : val_r;
  assign sp_cur_age  = rbe ? hi_age : age_r;
  assign sp_prev_val = lo_link.rbe ? val_r : lo_val;
  assign sp_prev_age = lo_link.rbe ? age_r : lo_age;
  assign lep_cur     = rbe ? hi_le : le;
  assign lep_prev    = lo_link.rbe ? le : lo_link.le;

  always_comb begin
    if (lep_cur) begin
      val_nxt = sp_cur_val;
      age_nxt = sp_cur_age + AgeW'(1);
    end else if (lep_prev) begin
      val_nxt = sample;
      age_nxt = '0;
    end else begin
      val_nxt = sp_prev_val;
      age_nxt = sp_prev_age + AgeW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  // Lower half counts negative, upper half positive; an odd window's median cancels out
  assign val_ext = {val_r[SAMPLE_W-1], val_r};

  always_comb begin
    if (IdxC >= win_len) begin
      term = '0;
    end else if (IdxC < low_cnt) begin
      if (win_len[0] && (IdxC == low_cnt - CntW'(1))) begin
        term = '0;
      end else begin
        term = -val_ext;
      end
    end else begin
      term = val_ext;
    end
  end

endmodule

// ----- hw/rtl/swmc_sum_tree.sv -----
module swmc_sum_tree #(
  parameter int NumIn = 64,
  parameter int AccW  = 39
) (
  input  logic                                clk,
  input  logic signed [swmc_pkg::TERM_W-1:0]  term [NumIn],
  output logic signed [AccW-1:0]              sum
);
  import swmc_pkg::*;

  localparam int Lvl = $clog2(NumIn);
  localparam int P   = 1 << Lvl;

  // heap layout: node 0 is the root, leaves at P-1 .. 2P-2
  logic signed [AccW-1:0] node_r [2*P-1];

  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < NumIn) begin : g_used
      always_ff @(posedge clk) begin
        node_r[P-1+g] <= AccW'(term[g]);
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        node_r[P-1+g] <= '0;
      end
    end
  end

  for (genvar g = 0; g < P - 1; g++) begin : g_node
    always_ff @(posedge clk) begin
      node_r[g] <= node_r[2*g+1] + node_r[2*g+2];
    end
  end

  assign sum = node_r[0];

endmodule
